[src/fvt_pkg.sv]
// shared types, constants and codes for the frustum visibility test unit
// no dependencies; imported by every module of the block
package fvt_pkg;

    // plane set size and register layout
    localparam int MAX_PLANES     = 6;
    localparam int NUM_PLANE_REGS = 6;
    localparam int COUNT_W        = $clog2(MAX_PLANES + 1);
    localparam int PLANE_IDX_W    = $clog2(NUM_PLANE_REGS);

    // configuration port
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 64;
    localparam logic [CFG_INDEX_W-1:0] REG_PLANE_COUNT = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_PLANE_A     = 3'd1;

    // stream payload widths
    localparam int S_TDATA_W = 160;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 8;

    // arithmetic widths
    localparam int COORD_W = 17;   // pos + corner offset, no wrap
    localparam int PROD_W  = 33;   // q1.14 normal times 17-bit coordinate
    localparam int DIST_W  = 35;   // three products plus scaled d
    localparam int FRAC_SH = 14;   // aligns q12.4 terms to 18 fraction bits

    typedef enum logic [1:0] {
        FUNC_POINT  = 2'd0,
        FUNC_SPHERE = 2'd1,
        FUNC_BOX    = 2'd2,
        FUNC_NONE   = 2'd3
    } func_t;

    typedef logic signed [15:0]        q16_t;
    typedef logic signed [COORD_W-1:0] coord_t;
    typedef logic signed [PROD_W-1:0]  prod_t;
    typedef logic signed [DIST_W-1:0]  dist_t;
    typedef logic        [14:0]        radius_t;

    // one plane register: nx in the low bits, d in the high bits
    typedef struct packed {
        q16_t d;
        q16_t nz;
        q16_t ny;
        q16_t nx;
    } plane_t;

    // stage load enables handed to each plane lane
    typedef struct packed {
        logic en2;
        logic en3;
    } stage_ctl_t;

endpackage

[src/fvt_cfg_regs.sv]
// configuration registers: plane count with saturation and six plane words
// depends on fvt_pkg
module fvt_cfg_regs (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_we,
    input  logic [fvt_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [fvt_pkg::CFG_DATA_W-1:0]      cfg_wdata,
    output logic [fvt_pkg::COUNT_W-1:0]         plane_count,
    output fvt_pkg::plane_t                     planes [fvt_pkg::NUM_PLANE_REGS]
);
    import fvt_pkg::*;

    logic [COUNT_W-1:0]          count_reg;
    logic [COUNT_W-1:0]          count_next;
    plane_t                      plane_reg  [NUM_PLANE_REGS];
    plane_t                      plane_next [NUM_PLANE_REGS];
    logic [CFG_INDEX_W-1:0]      plane_off;

    assign plane_off = cfg_index - REG_PLANE_A;

    // write decode, count saturates at the plane limit
    always_comb begin
        count_next = count_reg;
        for (int i = 0; i < NUM_PLANE_REGS; i++) begin
            plane_next[i] = plane_reg[i];
        end
        if (cfg_we) begin
            if (cfg_index == REG_PLANE_COUNT) begin
                if (cfg_wdata[COUNT_W-1:0] > COUNT_W'(MAX_PLANES)) begin
                    count_next = COUNT_W'(MAX_PLANES);
                end else begin
                    count_next = cfg_wdata[COUNT_W-1:0];
                end
            end else if (cfg_index >= REG_PLANE_A &&
                         cfg_index < REG_PLANE_A + CFG_INDEX_W'(NUM_PLANE_REGS)) begin
                plane_next[plane_off[PLANE_IDX_W-1:0]] = plane_t'(cfg_wdata);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            for (int i = 0; i < NUM_PLANE_REGS; i++) begin
                plane_reg[i] <= '0;
            end
        end else begin
            count_reg <= count_next;
            for (int i = 0; i < NUM_PLANE_REGS; i++) begin
                plane_reg[i] <= plane_next[i];
            end
        end
    end

    assign plane_count = count_reg;
    always_comb begin
        for (int i = 0; i < NUM_PLANE_REGS; i++) begin
            planes[i] = plane_reg[i];
        end
    end

endmodule

[src/fvt_plane_lane.sv]
// one plane lane: corner select and products, then sum and sign test
// depends on fvt_pkg; valid bits and enables come from the top level
module fvt_plane_lane (
    input  logic                 aclk,
    input  fvt_pkg::stage_ctl_t  ctl,
    input  fvt_pkg::plane_t      plane,
    input  fvt_pkg::func_t       func1,
    input  fvt_pkg::coord_t      pos1 [3],
    input  fvt_pkg::coord_t      lo1  [3],
    input  fvt_pkg::coord_t      hi1  [3],
    input  fvt_pkg::func_t       func2,
    input  fvt_pkg::radius_t     radius2,
    output logic                 culled
);
    import fvt_pkg::*;

    q16_t   normal [3];
    coord_t pt     [3];
    prod_t  prod_reg  [3];
    prod_t  prod_next [3];
    q16_t   d_reg;
    dist_t  rad_term;
    dist_t  dist_sum;
    logic   culled_reg;
    logic   culled_next;

    assign normal[0] = plane.nx;
    assign normal[1] = plane.ny;
    assign normal[2] = plane.nz;

    // box takes the farthest corner per axis, other tests the position
    always_comb begin
        for (int a = 0; a < 3; a++) begin
            if (func1 == FUNC_BOX) begin
                pt[a] = (normal[a] > 0) ? hi1[a] : lo1[a];
            end else begin
                pt[a] = pos1[a];
            end
            prod_next[a] = prod_t'(normal[a]) * prod_t'(pt[a]);
        end
    end

    // product stage
    always_ff @(posedge aclk) begin
        if (ctl.en2) begin
            for (int a = 0; a < 3; a++) begin
                prod_reg[a] <= prod_next[a];
            end
            d_reg <= plane.d;
        end
    end

    // sphere folds the radius in: -dist > r  <=>  dist + r < 0
    assign rad_term = (func2 == FUNC_SPHERE) ? dist_t'({radius2, FRAC_SH'(0)}) : '0;
    assign dist_sum = dist_t'(prod_reg[0]) + dist_t'(prod_reg[1]) + dist_t'(prod_reg[2])
                    + (dist_t'(d_reg) <<< FRAC_SH) + rad_term;
    assign culled_next = dist_sum[DIST_W-1];

    // sign stage
    always_ff @(posedge aclk) begin
        if (ctl.en3) begin
            culled_reg <= culled_next;
        end
    end

    assign culled = culled_reg;

endmodule

[src/frustum_visibility_test_unit.sv]
// top level of the frustum visibility test: input stage, plane lanes, merge
// depends on fvt_pkg, fvt_cfg_regs and fvt_plane_lane
//
//  channel  | handshake          | payload
//  ---------+--------------------+---------------------------------------------
//  s_ in    | s_tvalid/s_tready  | s_tdata objects, s_tuser test kind
//  m_ out   | m_tvalid/m_tready  | m_tdata visible flag
//  cfg      | cfg_we             | cfg_index, cfg_wdata (write only)
//
// one object per cycle sustained while m_ is not stalled; a beat taken passes
// four register stages on its way to m_: corner sums, per-plane products,
// per-plane sum and sign, merge over the active planes, which drives m_.
// reset (aresetn low, synchronous) empties the pipeline and zeroes the
// configuration registers. each stage loads when it is empty or the next
// one moves, so bubbles close up and a stalled output holds its beat.
module frustum_visibility_test_unit (
    input  logic                               aclk,
    input  logic                               aresetn,
    // configuration
    input  logic                               cfg_we,
    input  logic [fvt_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [fvt_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    // input stream
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // pos_x, pos_y, pos_z, radius, box_lo_x, box_lo_y, box_lo_z,
    // box_hi_x, box_hi_y, box_hi_z, one zero pad bit
    input  logic [fvt_pkg::S_TDATA_W-1:0]      s_tdata,
    // func
    input  logic [fvt_pkg::S_TUSER_W-1:0]      s_tuser,
    // result stream
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // visible, seven zero pad bits
    output logic [fvt_pkg::M_TDATA_W-1:0]      m_tdata
);
    import fvt_pkg::*;

    // unpacked input fields
    q16_t    in_pos [3];
    q16_t    in_lo  [3];
    q16_t    in_hi  [3];
    radius_t in_radius;

    assign in_pos[0] = s_tdata[15:0];
    assign in_pos[1] = s_tdata[31:16];
    assign in_pos[2] = s_tdata[47:32];
    assign in_radius = s_tdata[62:48];
    assign in_lo[0]  = s_tdata[78:63];
    assign in_lo[1]  = s_tdata[94:79];
    assign in_lo[2]  = s_tdata[110:95];
    assign in_hi[0]  = s_tdata[126:111];
    assign in_hi[1]  = s_tdata[142:127];
    assign in_hi[2]  = s_tdata[158:143];

    // configuration registers
    logic [COUNT_W-1:0] plane_count;
    plane_t             cfg_planes [NUM_PLANE_REGS];

    fvt_cfg_regs u_cfg (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata),
        .plane_count (plane_count),
        .planes      (cfg_planes)
    );

    // stage valids and ready chain
    logic v1_reg, v2_reg, v3_reg, m_valid_reg;
    logic rdy1, rdy2, rdy3, rdy4;

    assign rdy4 = !m_valid_reg || m_tready;
    assign rdy3 = !v3_reg || rdy4;
    assign rdy2 = !v2_reg || rdy3;
    assign rdy1 = !v1_reg || rdy2;
    assign s_tready = rdy1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg      <= 1'b0;
            v2_reg      <= 1'b0;
            v3_reg      <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (rdy1) v1_reg      <= s_tvalid;
            if (rdy2) v2_reg      <= v1_reg;
            if (rdy3) v3_reg      <= v2_reg;
            if (rdy4) m_valid_reg <= v3_reg;
        end
    end

    // stage 1: widened corner sums
    func_t   func1_reg;
    radius_t radius1_reg;
    coord_t  pos1_reg [3];
    coord_t  lo1_reg  [3];
    coord_t  hi1_reg  [3];

    always_ff @(posedge aclk) begin
        if (rdy1) begin
            func1_reg   <= func_t'(s_tuser);
            radius1_reg <= in_radius;
            for (int a = 0; a < 3; a++) begin
                pos1_reg[a] <= coord_t'(in_pos[a]);
                lo1_reg[a]  <= coord_t'(in_pos[a]) + coord_t'(in_lo[a]);
                hi1_reg[a]  <= coord_t'(in_pos[a]) + coord_t'(in_hi[a]);
            end
        end
    end

    // stages 2 and 3 sideband
    func_t   func2_reg;
    radius_t radius2_reg;
    func_t   func3_reg;

    always_ff @(posedge aclk) begin
        if (rdy2) begin
            func2_reg   <= func1_reg;
            radius2_reg <= radius1_reg;
        end
        if (rdy3) begin
            func3_reg <= func2_reg;
        end
    end

    // plane lanes, a plane without a register reads as zero
    stage_ctl_t            lane_ctl;
    logic [MAX_PLANES-1:0] lane_culled;

    assign lane_ctl.en2 = rdy2;
    assign lane_ctl.en3 = rdy3;

    for (genvar i = 0; i < MAX_PLANES; i++) begin : g_lane
        plane_t lane_plane;
        if (i < NUM_PLANE_REGS) begin : g_reg
            assign lane_plane = cfg_planes[i];
        end else begin : g_zero
            assign lane_plane = '0;
        end

        fvt_plane_lane u_lane (
            .aclk    (aclk),
            .ctl     (lane_ctl),
            .plane   (lane_plane),
            .func1   (func1_reg),
            .pos1    (pos1_reg),
            .lo1     (lo1_reg),
            .hi1     (hi1_reg),
            .func2   (func2_reg),
            .radius2 (radius2_reg),
            .culled  (lane_culled[i])
        );
    end

    // stage 4: merge over active planes
    logic [MAX_PLANES-1:0] active_mask;
    logic                  visible_reg;
    logic                  visible_next;

    always_comb begin
        for (int i = 0; i < MAX_PLANES; i++) begin
            active_mask[i] = (COUNT_W'(i) < plane_count);
        end
        visible_next = (func3_reg == FUNC_NONE) || !(|(lane_culled & active_mask));
    end

    always_ff @(posedge aclk) begin
        if (rdy4) begin
            visible_reg <= visible_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(M_TDATA_W-1){1'b0}}, visible_reg};

`ifndef NO_ASSERTIONS
    // reset leaves no result pending
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    // an empty pipeline always takes a beat
    a_empty_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        (!v1_reg && !v2_reg && !v3_reg && !m_valid_reg) |-> s_tready)
        else $error("empty pipeline refuses input");

    // a beat in stage 1 that moves lands in stage 2
    a_stage_advance: assert property (@(posedge aclk) disable iff (!aresetn)
        (v1_reg && rdy2) |=> v2_reg)
        else $error("beat lost between stage 1 and stage 2");

    // a blocked stage 3 keeps its beat and sideband
    a_stage3_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (v3_reg && !rdy4) |=> (v3_reg && $stable(func3_reg) && $stable(lane_culled)))
        else $error("stage 3 changed while stalled");
`endif

endmodule
